// ----- rtl/binary_heap_priority_queue_assert.svh -----
// Assertion macros for the binary heap priority queue.
// Included by the top level; depends on nothing else.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define BHPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bhpq: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define BHPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bhpq: next-cycle check failed");
`else
`define BHPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define BHPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/bhpq_pkg.sv -----
// Shared types, constants and the key compare for the binary heap priority queue.
// No dependencies.
package bhpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 7;
  localparam int CFG_ADDR_W   = 3;

  typedef logic signed [KEY_W-1:0] key_t;

  // Input operation codes.
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Register map.
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_ORDER = 3'd0;

  typedef struct packed {
    logic op;
    key_t key;
  } req_t;

  typedef struct packed {
    logic                ok;
    key_t                key;
    logic [COUNT_W-1:0]  count;
  } res_t;

  // True when key a must sit above key b in the heap.
  function automatic logic ranks_above(input key_t a, input key_t b, input logic min_order);
    ranks_above = min_order ? (a < b) : (a > b);
  endfunction

endpackage

// ----- rtl/bhpq_core.sv -----
// Heap sequencer with its key store and a single shared key comparator.
// Depends on bhpq_pkg.
module bhpq_core import bhpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic min_order,
  input  logic start_valid,
  output logic start_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_EX_LD, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_L, S_DN_R, S_FIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  key_t            key_r, key_nxt;
  key_t            got_r, got_nxt;
  key_t            best_r, best_nxt;
  logic            ok_r, ok_nxt;
  logic            lwin_r, lwin_nxt;

  // Key store: one write port, two registered read ports.
  key_t            mem [CAPACITY];
  key_t            rd0_r, rd1_r;
  logic            we, rd_en;
  logic [AW-1:0]   wa, ra0, ra1;
  key_t            wd;

  logic [AW-1:0]   parent;
  logic [XW-1:0]   lc, rc, n_ext;
  logic [AW-1:0]   last_idx;
  key_t            cmp_a, cmp_b;
  logic            above;

  // Heap index arithmetic.
  assign parent   = AW'((pos_r - AW'(1)) >> 1);
  assign lc       = {1'b0, pos_r, 1'b1};
  assign rc       = lc + XW'(1);
  assign n_ext    = XW'(cnt_r);
  assign last_idx = AW'(cnt_r - CW'(1));

  // Operand select for the shared comparator.
  always_comb begin
    cmp_a = key_r;
    cmp_b = rd0_r;
    case (state_r)
      S_DN_L: begin
        cmp_a = rd0_r;
        cmp_b = key_r;
      end
      S_DN_R: begin
        cmp_a = rd1_r;
        cmp_b = best_r;
      end
      default: begin
        cmp_a = key_r;
        cmp_b = rd0_r;
      end
    endcase
  end

  assign above = ranks_above(cmp_a, cmp_b, min_order);

  // Sequencer next-state and store access.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    got_nxt   = got_r;
    best_nxt  = best_r;
    ok_nxt    = ok_r;
    lwin_nxt  = lwin_r;
    we        = 1'b0;
    wa        = pos_r;
    wd        = key_r;
    rd_en     = 1'b0;
    ra0       = parent;
    ra1       = rc[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start_valid) begin
          rd_en   = 1'b1;
          ra0     = '0;
          ra1     = last_idx;
          got_nxt = '0;
          if (req.op == OP_INSERT) begin
            if (cnt_r < CW'(CAPACITY)) begin
              key_nxt   = req.key;
              pos_nxt   = cnt_r[AW-1:0];
              cnt_nxt   = cnt_r + CW'(1);
              ok_nxt    = 1'b1;
              state_nxt = S_UP_RD;
            end else begin
              ok_nxt    = 1'b0;
              state_nxt = S_FIN;
            end
          end else begin
            if (cnt_r != '0) begin
              ok_nxt    = 1'b1;
              state_nxt = S_EX_LD;
            end else begin
              ok_nxt    = 1'b0;
              state_nxt = S_FIN;
            end
          end
        end
      end
      // Root and last entry have been read: take the root, sift the last down.
      S_EX_LD: begin
        got_nxt = rd0_r;
        key_nxt = rd1_r;
        cnt_nxt = cnt_r - CW'(1);
        pos_nxt = '0;
        if (cnt_r == CW'(1)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end
      // Parent moves down into the hole when the new key ranks above it.
      S_UP_CMP: begin
        we = 1'b1;
        if (above) begin
          wd        = rd0_r;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_RD: begin
        rd_en     = 1'b1;
        ra0       = lc[AW-1:0];
        ra1       = rc[AW-1:0];
        state_nxt = S_DN_L;
      end
      S_DN_L: begin
        lwin_nxt  = (lc < n_ext) && above;
        best_nxt  = ((lc < n_ext) && above) ? rd0_r : key_r;
        state_nxt = S_DN_R;
      end
      // The right child wins only if strictly better than the left winner.
      S_DN_R: begin
        we = 1'b1;
        if ((rc < n_ext) && above) begin
          wd        = rd1_r;
          pos_nxt   = rc[AW-1:0];
          state_nxt = S_DN_RD;
        end else if (lwin_r) begin
          wd        = rd0_r;
          pos_nxt   = lc[AW-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r  <= pos_nxt;
    key_r  <= key_nxt;
    got_r  <= got_nxt;
    best_r <= best_nxt;
    ok_r   <= ok_nxt;
    lwin_r <= lwin_nxt;
  end

  // Key store.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd0_r <= mem[ra0];
      rd1_r <= mem[ra1];
    end
  end

  assign start_ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_FIN);
  assign res.ok      = ok_r;
  assign res.key     = got_r;
  assign res.count   = COUNT_W'(cnt_r);

endmodule

// ----- rtl/binary_heap_priority_queue.sv -----
// Binary heap priority queue of signed 32-bit keys.
// Input words carry an insert or an extract; each gives one result word.
// Both channels use a valid/ready handshake; a word moves when both are high.
// The input word holds the key in in_tdata and the opcode in in_tuser
// (0 inserts, 1 extracts the root). The result word holds the extracted key
// and the entry count in out_tdata and the success flag in out_tuser.
// One word is worked at a time: the next word is taken only once the result
// has passed into the output register and the sequencer is idle again. A
// refused word skips the heap walk. Each level of the heap costs one read
// of the key store plus one or two passes through the single key comparator.
// Reset (rst_n, synchronous) empties the heap and selects min-heap order.
// A result waits in the output register while the receiver stalls; the next
// word is still taken and worked, and it holds in the sequencer until the
// output register frees up. The order register must be written over the APB
// port only while the block is idle; the block itself does not enforce this.
// Keys already held are not reordered.
`include "binary_heap_priority_queue_assert.svh"
module binary_heap_priority_queue import bhpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,     // [31:0] key_in
  input  logic                  in_tuser,     // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,    // [31:0] key_out, [38:32] count, [39] zero
  output logic                  out_tuser,    // [0] ok
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic min_order_r;
  logic cfg_wr;
  req_t req;
  res_t core_res;
  logic res_valid, res_ready;
  logic out_valid_r;
  res_t out_res_r;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_MIN_ORDER) ? {31'b0, min_order_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_order_r <= 1'b1;
    end else if (cfg_wr && (cfg_paddr == REG_MIN_ORDER)) begin
      min_order_r <= cfg_pwdata[0];
    end
  end

  // Heap sequencer.
  assign req.op  = in_tuser;
  assign req.key = in_tdata;

  bhpq_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .min_order  (min_order_r),
    .start_valid(in_tvalid),
    .start_ready(in_tready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (core_res)
  );

  // Output register.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ok;
  assign out_tdata  = {1'b0, out_res_r.count, out_res_r.key};

  // Checks.
  `BHPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BHPQ_ASSERT_NEXT(a_result_registered, clk, rst_n, res_valid && res_ready, out_tvalid)
  `BHPQ_ASSERT_NOW(a_refused_key_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[31:0] == '0)

endmodule
